### design/contiguous_first_worst_fit_allocator_defines.svh
// ----------------------------------------------------------------------------
// contiguous first/worst fit allocator - assertion macros
// Shared property wrappers for the allocator checks, clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_FIRST_WORST_FIT_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_FIRST_WORST_FIT_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define CFWF_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CFWF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/cfwf_pkg.sv
// ----------------------------------------------------------------------------
// cfwf_pkg
// Constants, status codes and controller/datapath types of the contiguous
// cell allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package cfwf_pkg;

	localparam int MEM_CELLS = 1024;
	localparam int MAX_PROCS = 128;
	localparam int ADDR_W    = $clog2(MEM_CELLS);
	localparam int CNT_W     = ADDR_W + 1;
	localparam int PIDX_W    = $clog2(MAX_PROCS);
	localparam int FIELD_W   = 11;
	localparam int ID_W      = 7;
	localparam int STATUS_W  = 3;
	localparam int POLICY_W  = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic [STATUS_W-1:0] STS_ALLOC   = 3'd0;
	localparam logic [STATUS_W-1:0] STS_NOFIT   = 3'd1;
	localparam logic [STATUS_W-1:0] STS_FREED   = 3'd2;
	localparam logic [STATUS_W-1:0] STS_NOTLIVE = 3'd3;
	localparam logic [STATUS_W-1:0] STS_LIVE    = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_CELLS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY  = 1'd1;

	localparam logic [POLICY_W-1:0] POLICY_LARGEST = 2'd1;

	localparam logic [FIELD_W-1:0]  RESET_TOTAL  = 11'd1024;
	localparam logic [POLICY_W-1:0] RESET_POLICY = 2'd2;

	typedef struct packed {
		logic                clr_step;
		logic                load;
		logic                res_set;
		logic [STATUS_W-1:0] res_code;
		logic                mark_freed;
		logic                free_commit;
		logic                scan_begin;
		logic                scan_step;
		logic                alloc_commit;
		logic                claim_step;
		logic                fscan_step;
		logic                out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic func_free;
		logic id_ok;
		logic id_live;
		logic scan_done;
		logic hole_found;
		logic size_zero;
		logic claim_last;
		logic fscan_done;
		logic out_busy;
	} sts_t;

endpackage

`default_nettype wire

### design/cfwf_ifs.sv
// ----------------------------------------------------------------------------
// cfwf request and response channels
// Valid/ready channels carrying allocator requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfwf_req_if;
	logic                           valid;
	logic                           ready;
	logic                           func;
	logic [cfwf_pkg::ID_W-1:0]      proc_id;
	logic [cfwf_pkg::FIELD_W-1:0]   req_size;

	modport source (output valid, func, proc_id, req_size, input ready);
	modport sink (input valid, func, proc_id, req_size, output ready);
endinterface

interface cfwf_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [cfwf_pkg::STATUS_W-1:0]  status;
	logic [cfwf_pkg::FIELD_W-1:0]   base_addr;
	logic [cfwf_pkg::FIELD_W-1:0]   end_addr;
	logic [cfwf_pkg::FIELD_W-1:0]   free_cells;

	modport source (output valid, status, base_addr, end_addr, free_cells, input ready);
	modport sink (input valid, status, base_addr, end_addr, free_cells, output ready);
endinterface

`default_nettype wire

### design/contiguous_first_worst_fit_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_first_worst_fit_allocator
// Contiguous cell allocator with first-fit and largest-hole placement.
// Allocate reads the owner map, one owner map read per cycle over the
// searched cells, then one write per claimed cell; free runs a
// read-compare-clear sweep over the whole map. One item at a time; the
// result register lets the next item enter while a result waits. Reset
// clears control at once, then a clearing pass over the whole owner map
// runs before the first item is taken; config writes are taken always.
// ----------------------------------------------------------------------------
`default_nettype none
`include "contiguous_first_worst_fit_allocator_defines.svh"

module contiguous_first_worst_fit_allocator (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [cfwf_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [cfwf_pkg::FIELD_W-1:0]      cfg_data,
	cfwf_req_if.sink                               req,
	cfwf_rsp_if.source                             rsp
);

	logic [cfwf_pkg::FIELD_W-1:0]  total_cells_q;
	logic [cfwf_pkg::POLICY_W-1:0] fit_policy_q;
	cfwf_pkg::cmd_t                cmd;
	cfwf_pkg::sts_t                sts;
	logic                          in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_cells_q <= cfwf_pkg::RESET_TOTAL;
			fit_policy_q  <= cfwf_pkg::RESET_POLICY;
		end else if (cfg_we) begin
			case (cfg_idx)
				cfwf_pkg::REG_TOTAL_CELLS: total_cells_q <= cfg_data;
				cfwf_pkg::REG_FIT_POLICY:  fit_policy_q  <= cfg_data[cfwf_pkg::POLICY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign req.ready = in_ready;

	cfwf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cfwf_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_func     (req.func),
		.in_proc_id  (req.proc_id),
		.in_req_size (req.req_size),
		.total_cells (total_cells_q),
		.fit_policy  (fit_policy_q),
		.out_ready   (rsp.ready),
		.out_valid   (rsp.valid),
		.status      (rsp.status),
		.base_addr   (rsp.base_addr),
		.end_addr    (rsp.end_addr),
		.free_cells  (rsp.free_cells)
	);

	`CFWF_ASSERT_NEXT(a_one_item, req.valid && req.ready, !req.ready, "item taken while busy")
	`CFWF_ASSERT_IMPLIES(a_reject_no_run, rsp.valid && (rsp.status != cfwf_pkg::STS_ALLOC), (rsp.base_addr == '0) && (rsp.end_addr == '0), "run reported on a rejected item")
	`CFWF_ASSERT_IMPLIES(a_run_in_map, rsp.valid && (rsp.status == cfwf_pkg::STS_ALLOC), (rsp.end_addr >= rsp.base_addr) && (rsp.end_addr <= cfwf_pkg::FIELD_W'(cfwf_pkg::MEM_CELLS)), "placed run outside the map")

endmodule

`default_nettype wire

### design/cfwf_datapath.sv
// ----------------------------------------------------------------------------
// cfwf_datapath
// Owner map memory, process tables, hole scan tracker, claim and release
// sweeps, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfwf_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire cfwf_pkg::cmd_t                  cmd,
	output cfwf_pkg::sts_t                       sts,
	input  wire logic                            in_func,
	input  wire logic [cfwf_pkg::ID_W-1:0]       in_proc_id,
	input  wire logic [cfwf_pkg::FIELD_W-1:0]    in_req_size,
	input  wire logic [cfwf_pkg::FIELD_W-1:0]    total_cells,
	input  wire logic [cfwf_pkg::POLICY_W-1:0]   fit_policy,
	input  wire logic                            out_ready,
	output logic                                 out_valid,
	output logic [cfwf_pkg::STATUS_W-1:0]        status,
	output logic [cfwf_pkg::FIELD_W-1:0]         base_addr,
	output logic [cfwf_pkg::FIELD_W-1:0]         end_addr,
	output logic [cfwf_pkg::FIELD_W-1:0]         free_cells
);

	localparam int ADDR_W  = cfwf_pkg::ADDR_W;
	localparam int CNT_W   = cfwf_pkg::CNT_W;
	localparam int PIDX_W  = cfwf_pkg::PIDX_W;
	localparam int FIELD_W = cfwf_pkg::FIELD_W;
	localparam int ID_W    = cfwf_pkg::ID_W;

	// latched item
	logic               func_q;
	logic [ID_W-1:0]    id_q;
	logic [FIELD_W-1:0] size_q;

	// process tables
	logic [cfwf_pkg::MAX_PROCS-1:0] live_q;
	logic [FIELD_W-1:0]             pc_mem [cfwf_pkg::MAX_PROCS];
	logic [FIELD_W-1:0]             pc_rd_q;

	// owner map
	logic [ID_W-1:0]   owner_mem [cfwf_pkg::MEM_CELLS];
	logic [ID_W-1:0]   rd_data_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              rd_v_s1;
	logic [CNT_W-1:0]  cnt_q;

	// hole tracking
	logic              in_run_q;
	logic [ADDR_W-1:0] run_start_q;
	logic [CNT_W-1:0]  run_len_q;
	logic              first_found_q;
	logic [ADDR_W-1:0] first_base_q;
	logic              best_found_q;
	logic [ADDR_W-1:0] best_base_q;
	logic [CNT_W-1:0]  best_len_q;

	logic [CNT_W-1:0]   used_q;
	logic               freed_once_q;
	logic [CNT_W-1:0]   wr_ptr_q;
	logic [FIELD_W-1:0] remain_q;

	logic [cfwf_pkg::STATUS_W-1:0] res_code_q;
	logic [FIELD_W-1:0]            res_base_q;
	logic [FIELD_W-1:0]            res_end_q;

	logic [cfwf_pkg::STATUS_W-1:0] out_status_q;
	logic [FIELD_W-1:0]            out_base_q;
	logic [FIELD_W-1:0]            out_end_q;
	logic [FIELD_W-1:0]            out_free_q;
	logic                          out_valid_q;

	logic [CNT_W-1:0]   t_eff;
	logic [PIDX_W-1:0]  pidx;
	logic               id_ok;
	logic               rd_en;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [ID_W-1:0]    mem_wdata;
	logic               cell_free;
	logic               last_cell;
	logic               close_run;
	logic [CNT_W-1:0]   cur_len;
	logic [ADDR_W-1:0]  cur_start;
	logic               fits;
	logic               largest;
	logic [ADDR_W-1:0]  chosen;
	logic [CNT_W-1:0]   free_now;

	assign t_eff = (total_cells > CNT_W'(cfwf_pkg::MEM_CELLS)) ?
		CNT_W'(cfwf_pkg::MEM_CELLS) : CNT_W'(total_cells);
	assign pidx  = id_q[PIDX_W-1:0];
	assign id_ok = (id_q != '0) && ({1'b0, id_q} < (ID_W + 1)'(cfwf_pkg::MAX_PROCS));

	assign rd_en = (cmd.scan_step && (cnt_q < t_eff))
		|| (cmd.fscan_step && (cnt_q != CNT_W'(cfwf_pkg::MEM_CELLS)));

	assign mem_we = cmd.clr_step || cmd.claim_step
		|| (cmd.fscan_step && rd_v_s1 && (rd_data_s1 == id_q));

	always_comb begin
		mem_waddr = addr_s1;
		mem_wdata = '0;
		if (cmd.clr_step) begin
			mem_waddr = cnt_q[ADDR_W-1:0];
		end else if (cmd.claim_step) begin
			mem_waddr = wr_ptr_q[ADDR_W-1:0];
			mem_wdata = id_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			owner_mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_data_s1 <= owner_mem[cnt_q[ADDR_W-1:0]];
			addr_s1    <= cnt_q[ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pc_rd_q <= pc_mem[in_proc_id[PIDX_W-1:0]];
		end
		if (cmd.alloc_commit) begin
			pc_mem[pidx] <= size_q;
		end
	end

	// run closes on an owned cell or at the last searched cell
	assign cell_free = (rd_data_s1 == '0);
	assign last_cell = (CNT_W'(addr_s1) == t_eff - CNT_W'(1));
	assign close_run = (cell_free || in_run_q) && (!cell_free || last_cell);
	assign cur_start = in_run_q ? run_start_q : addr_s1;
	always_comb begin
		if (!cell_free) begin
			cur_len = run_len_q;
		end else if (in_run_q) begin
			cur_len = run_len_q + CNT_W'(1);
		end else begin
			cur_len = CNT_W'(1);
		end
	end
	assign fits = (FIELD_W'(cur_len) >= size_q);

	assign largest = (fit_policy == cfwf_pkg::POLICY_LARGEST) || (fit_policy[1] && freed_once_q);
	assign chosen  = largest ? best_base_q : first_base_q;

	assign free_now = (used_q >= t_eff) ? '0 : t_eff - used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			rd_v_s1       <= 1'b0;
			in_run_q      <= 1'b0;
			first_found_q <= 1'b0;
			best_found_q  <= 1'b0;
			live_q        <= '0;
			used_q        <= '0;
			freed_once_q  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			rd_v_s1 <= rd_en;

			if (cmd.clr_step) begin
				cnt_q <= (cnt_q == CNT_W'(cfwf_pkg::MEM_CELLS - 1)) ? '0 : cnt_q + CNT_W'(1);
			end else if (cmd.scan_begin) begin
				cnt_q <= '0;
			end else if (rd_en) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end

			if (cmd.scan_begin) begin
				in_run_q      <= 1'b0;
				first_found_q <= 1'b0;
				best_found_q  <= 1'b0;
			end else if (cmd.scan_step && rd_v_s1) begin
				if (close_run) begin
					in_run_q <= 1'b0;
					if (fits && !first_found_q) begin
						first_found_q <= 1'b1;
					end
					if (fits && (!best_found_q || (cur_len > best_len_q))) begin
						best_found_q <= 1'b1;
					end
				end else if (cell_free) begin
					in_run_q <= 1'b1;
				end
			end

			if (cmd.mark_freed) begin
				freed_once_q <= 1'b1;
			end

			if (cmd.free_commit) begin
				live_q[pidx] <= 1'b0;
				used_q <= (CNT_W'(pc_rd_q) >= used_q) ? '0 : used_q - CNT_W'(pc_rd_q);
			end else if (cmd.alloc_commit) begin
				live_q[pidx] <= 1'b1;
				used_q <= used_q + CNT_W'(size_q);
			end

			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q     <= in_func;
			id_q       <= in_proc_id;
			size_q     <= in_req_size;
			res_base_q <= '0;
			res_end_q  <= '0;
		end
		if (cmd.res_set) begin
			res_code_q <= cmd.res_code;
		end
		if (cmd.scan_step && rd_v_s1) begin
			if (close_run) begin
				if (fits && !first_found_q) begin
					first_base_q <= cur_start;
				end
				if (fits && (!best_found_q || (cur_len > best_len_q))) begin
					best_base_q <= cur_start;
					best_len_q  <= cur_len;
				end
			end else if (cell_free) begin
				run_start_q <= cur_start;
				run_len_q   <= cur_len;
			end
		end
		if (cmd.alloc_commit) begin
			res_base_q <= FIELD_W'(chosen);
			res_end_q  <= FIELD_W'(chosen) + size_q;
			wr_ptr_q   <= CNT_W'(chosen);
			remain_q   <= size_q;
		end else if (cmd.claim_step) begin
			wr_ptr_q <= wr_ptr_q + CNT_W'(1);
			remain_q <= remain_q - FIELD_W'(1);
		end
		if (cmd.out_load) begin
			out_status_q <= res_code_q;
			out_base_q   <= res_base_q;
			out_end_q    <= res_end_q;
			out_free_q   <= FIELD_W'(free_now);
		end
	end

	assign sts.clr_last   = (cnt_q == CNT_W'(cfwf_pkg::MEM_CELLS - 1));
	assign sts.func_free  = func_q;
	assign sts.id_ok      = id_ok;
	assign sts.id_live    = live_q[pidx];
	assign sts.scan_done  = (cnt_q >= t_eff) && !rd_v_s1;
	assign sts.hole_found = first_found_q;
	assign sts.size_zero  = (size_q == '0);
	assign sts.claim_last = (remain_q == FIELD_W'(1));
	assign sts.fscan_done = cnt_q[ADDR_W] && !rd_v_s1;
	assign sts.out_busy   = out_valid_q && !out_ready;

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign base_addr  = out_base_q;
	assign end_addr   = out_end_q;
	assign free_cells = out_free_q;

endmodule

`default_nettype wire

### design/cfwf_ctrl.sv
// ----------------------------------------------------------------------------
// cfwf_ctrl
// Sequencer of the allocator: map clearing after reset, request decode, hole
// scan, claim sweep, release sweep and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module cfwf_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire cfwf_pkg::sts_t sts,
	output cfwf_pkg::cmd_t      cmd
);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_CLAIM  = 3'd4;
	localparam logic [2:0] S_FREE   = 3'd5;
	localparam logic [2:0] S_FINISH = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.res_set = 1'b1;
				state_d     = S_FINISH;
				if (sts.func_free) begin
					cmd.mark_freed = 1'b1;
					if (sts.id_ok && sts.id_live) begin
						cmd.res_code    = cfwf_pkg::STS_FREED;
						cmd.free_commit = 1'b1;
						cmd.scan_begin  = 1'b1;
						state_d         = S_FREE;
					end else begin
						cmd.res_code = cfwf_pkg::STS_NOTLIVE;
					end
				end else if (!sts.id_ok) begin
					cmd.res_code = cfwf_pkg::STS_NOFIT;
				end else if (sts.id_live) begin
					cmd.res_code = cfwf_pkg::STS_LIVE;
				end else begin
					cmd.res_set    = 1'b0;
					cmd.scan_begin = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) begin
					cmd.res_set = 1'b1;
					if (sts.hole_found) begin
						cmd.res_code     = cfwf_pkg::STS_ALLOC;
						cmd.alloc_commit = 1'b1;
						state_d          = sts.size_zero ? S_FINISH : S_CLAIM;
					end else begin
						cmd.res_code = cfwf_pkg::STS_NOFIT;
						state_d      = S_FINISH;
					end
				end
			end
			S_CLAIM: begin
				cmd.claim_step = 1'b1;
				if (sts.claim_last) begin
					state_d = S_FINISH;
				end
			end
			S_FREE: begin
				cmd.fscan_step = 1'b1;
				if (sts.fscan_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				// wait for the result register to drain
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - contiguous cell allocator testbench
// Sends allocate and free items under first fit, largest hole and the
// switching policy at several cell totals, predicts every response from an
// owner map kept in the testbench and checks each response field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [cfwf_pkg::POLICY_W-1:0] POLICY_FIRST  = 2'd0;
	localparam logic [cfwf_pkg::POLICY_W-1:0] POLICY_SWITCH = 2'd2;
	localparam logic [cfwf_pkg::POLICY_W-1:0] POLICY_SPARE  = 2'd3;

	// no item may take longer than a full scan plus a full claim, plus pacing
	localparam int QUIET_LIMIT = 20000;

	typedef struct {
		logic [cfwf_pkg::STATUS_W-1:0] status;
		logic [cfwf_pkg::FIELD_W-1:0]  base_addr;
		logic [cfwf_pkg::FIELD_W-1:0]  end_addr;
		logic [cfwf_pkg::FIELD_W-1:0]  free_cells;
	} alloc_outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [cfwf_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [cfwf_pkg::FIELD_W-1:0] cfg_data;

	cfwf_req_if req_ch ();
	cfwf_rsp_if rsp_ch ();

	contiguous_first_worst_fit_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow of the allocator
	logic [cfwf_pkg::ID_W-1:0]     cell_owner [cfwf_pkg::MEM_CELLS];
	int                            held_by [cfwf_pkg::MAX_PROCS];
	bit                            id_live [cfwf_pkg::MAX_PROCS];
	int                            cells_held;
	bit                            ever_freed;
	logic [cfwf_pkg::FIELD_W-1:0]  cells_total;
	logic [cfwf_pkg::POLICY_W-1:0] fit_policy;

	alloc_outcome_t awaited_outcomes [$];
	int mismatches = 0;
	bit pacing_on;
	int quiet_cycles = 0;

	function automatic alloc_outcome_t allocator_outcome(input logic f,
			input logic [cfwf_pkg::ID_W-1:0] id, input logic [cfwf_pkg::FIELD_W-1:0] sz);
		alloc_outcome_t r;
		int span, i, j, run, best_len, base;
		bit id_ok, largest, found;
		r = '{default: '0};
		span = (cells_total > cfwf_pkg::MEM_CELLS) ? cfwf_pkg::MEM_CELLS : int'(cells_total);
		id_ok = (id != 0) && (id < cfwf_pkg::MAX_PROCS);
		if (f == FUNC_FREE) begin
			ever_freed = 1'b1;
			if (!id_ok || !id_live[id]) begin
				r.status = cfwf_pkg::STS_NOTLIVE;
			end else begin
				id_live[id] = 1'b0;
				cells_held = (held_by[id] >= cells_held) ? 0 : cells_held - held_by[id];
				// a free clears the whole map, not only the searched cells
				foreach (cell_owner[k])
					if (cell_owner[k] == id)
						cell_owner[k] = '0;
				r.status = cfwf_pkg::STS_FREED;
			end
		end else if (!id_ok) begin
			r.status = cfwf_pkg::STS_NOFIT;
		end else if (id_live[id]) begin
			r.status = cfwf_pkg::STS_LIVE;
		end else begin
			largest = (fit_policy == cfwf_pkg::POLICY_LARGEST) ||
				(fit_policy >= POLICY_SWITCH && ever_freed);
			found = 1'b0;
			best_len = 0;
			base = 0;
			i = 0;
			while (i < span && !(found && !largest)) begin
				if (cell_owner[i] != 0) begin
					i++;
				end else begin
					j = i;
					while (j < span && cell_owner[j] == 0)
						j++;
					run = j - i;
					// strictly larger keeps the lowest base on a tie
					if (run >= int'(sz) && (!found || run > best_len)) begin
						found = 1'b1;
						best_len = run;
						base = i;
					end
					i = j;
				end
			end
			if (found) begin
				for (int k = base; k < base + int'(sz); k++)
					cell_owner[k] = id;
				id_live[id] = 1'b1;
				held_by[id] = int'(sz);
				cells_held += int'(sz);
				r.status = cfwf_pkg::STS_ALLOC;
				r.base_addr = cfwf_pkg::FIELD_W'(base);
				r.end_addr = cfwf_pkg::FIELD_W'(base + int'(sz));
			end else begin
				r.status = cfwf_pkg::STS_NOFIT;
			end
		end
		r.free_cells = cfwf_pkg::FIELD_W'((cells_held >= span) ? 0 : span - cells_held);
		return r;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_request(input logic f, input logic [cfwf_pkg::ID_W-1:0] id,
			input logic [cfwf_pkg::FIELD_W-1:0] sz);
		int gap;
		gap = pacing_on ? $urandom_range(0, 9) : 0;
		if (gap != 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.func = f;
		req_ch.proc_id = id;
		req_ch.req_size = sz;
		do @(posedge clk); while (!req_ch.ready);
		awaited_outcomes.push_back(allocator_outcome(f, id, sz));
		@(negedge clk);
	endtask

	task automatic wait_for_outcomes();
		req_ch.valid = 1'b0;
		while (awaited_outcomes.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_registers(input logic [cfwf_pkg::FIELD_W-1:0] total,
			input logic [cfwf_pkg::POLICY_W-1:0] policy);
		wait_for_outcomes();
		cfg_we = 1'b1;
		cfg_idx = cfwf_pkg::REG_TOTAL_CELLS;
		cfg_data = total;
		@(negedge clk);
		cfg_idx = cfwf_pkg::REG_FIT_POLICY;
		cfg_data = cfwf_pkg::FIELD_W'(policy);
		@(negedge clk);
		cfg_we = 1'b0;
		cells_total = total;
		fit_policy = policy;
	endtask

	function automatic int pick_id(input bit want_live);
		int ids [$];
		for (int k = 1; k < cfwf_pkg::MAX_PROCS; k++)
			if (id_live[k] == want_live)
				ids.push_back(k);
		if (ids.size() == 0)
			return 0;
		return ids[$urandom_range(0, ids.size() - 1)];
	endfunction

	function automatic int draw_size();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			return 0;
		if (roll < 70)
			return $urandom_range(1, 48);
		if (roll < 92)
			return $urandom_range(49, 300);
		return $urandom_range(301, 2047);
	endfunction

	// mostly well-formed allocate/free pairs, some noise and repeats
	task automatic run_traffic(input int count);
		int roll, id, sz;
		logic f;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			f = FUNC_ALLOC;
			id = pick_id(1'b0);
			sz = draw_size();
			if (roll < 10) begin
				f = 1'($urandom_range(0, 1));
				id = $urandom_range(0, 127);
				sz = $urandom_range(0, 2047);
			end else if (roll < 18 && pick_id(1'b1) != 0) begin
				id = pick_id(1'b1);
			end else if (roll < 56 && pick_id(1'b1) != 0) begin
				f = FUNC_FREE;
				id = pick_id(1'b1);
				sz = $urandom_range(0, 2047);
			end
			send_request(f, cfwf_pkg::ID_W'(id), cfwf_pkg::FIELD_W'(sz));
		end
	endtask

	task automatic test_directed();
		pacing_on = 1'b1;
		// reset config: first fit until the first free item
		send_request(FUNC_ALLOC, 7'd1, 11'd100);
		send_request(FUNC_ALLOC, 7'd2, 11'd200);
		send_request(FUNC_ALLOC, 7'd1, 11'd5);
		send_request(FUNC_ALLOC, 7'd0, 11'd10);
		send_request(FUNC_ALLOC, 7'd3, 11'd2047);
		send_request(FUNC_ALLOC, 7'd127, 11'd0);
		send_request(FUNC_ALLOC, 7'd4, 11'd724);
		// map full: zero size has no base to sit on
		send_request(FUNC_ALLOC, 7'd5, 11'd0);
		send_request(FUNC_FREE, 7'd0, 11'd2047);
		send_request(FUNC_FREE, 7'd9, 11'd0);
		send_request(FUNC_FREE, 7'd1, 11'd0);
		send_request(FUNC_FREE, 7'd127, 11'd0);
		send_request(FUNC_FREE, 7'd4, 11'd1024);
		// largest hole from here on
		send_request(FUNC_ALLOC, 7'd6, 11'd50);
		send_request(FUNC_ALLOC, 7'd7, 11'd100);
		send_request(FUNC_ALLOC, 7'd8, 11'd474);
		// two holes of 100 cells: lowest base wins
		send_request(FUNC_ALLOC, 7'd9, 11'd100);
		send_request(FUNC_ALLOC, 7'd10, 11'd101);
		send_request(FUNC_ALLOC, 7'd11, 11'd100);
		send_request(FUNC_FREE, 7'd127, 11'd0);
		send_request(FUNC_ALLOC, 7'd127, 11'd1);
		send_request(FUNC_FREE, 7'd9, 11'd0);
		send_request(FUNC_ALLOC, 7'd127, 11'd0);
		send_request(FUNC_FREE, 7'd127, 11'd0);
		send_request(FUNC_ALLOC, 7'd12, 11'd100);
	endtask

	task automatic test_first_fit();
		set_registers(11'd1024, POLICY_FIRST);
		pacing_on = 1'b1;
		run_traffic(40);
	endtask

	task automatic test_largest_hole();
		set_registers(11'd1024, cfwf_pkg::POLICY_LARGEST);
		pacing_on = 1'b0;
		run_traffic(40);
	endtask

	task automatic test_lowered_total();
		set_registers(11'd256, POLICY_SWITCH);
		pacing_on = 1'b1;
		run_traffic(35);
	endtask

	task automatic test_single_cell();
		set_registers(11'd1, POLICY_FIRST);
		pacing_on = 1'b1;
		run_traffic(25);
	endtask

	task automatic test_zero_total();
		set_registers(11'd0, cfwf_pkg::POLICY_LARGEST);
		pacing_on = 1'b0;
		run_traffic(15);
	endtask

	task automatic test_oversized_total();
		set_registers(11'd2047, POLICY_SPARE);
		pacing_on = 1'b1;
		run_traffic(40);
	endtask

	task automatic test_mid_total();
		set_registers(11'd700, cfwf_pkg::POLICY_LARGEST);
		pacing_on = 1'b1;
		run_traffic(20);
	endtask

	task automatic test_switch_policy();
		set_registers(11'd1024, POLICY_SWITCH);
		pacing_on = 1'b1;
		run_traffic(45);
	endtask

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : check_results
		alloc_outcome_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_outcomes.size() == 0) begin
				$error("response with no item outstanding: status %0d", rsp_ch.status);
				mismatches++;
			end else begin
				want = awaited_outcomes.pop_front();
				compare_field("status", int'(want.status), int'(rsp_ch.status));
				compare_field("base_addr", int'(want.base_addr), int'(rsp_ch.base_addr));
				compare_field("end_addr", int'(want.end_addr), int'(rsp_ch.end_addr));
				compare_field("free_cells", int'(want.free_cells), int'(rsp_ch.free_cells));
			end
		end
	end

	initial begin : result_pacing
		int stall;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = pacing_on ? $urandom_range(0, 9) : 0;
			if (stall != 0) begin
				rsp_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready = 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	// covers the map clearing pass after reset as well
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[contiguous_first_worst_fit_allocator] ERROR");
			$finish;
		end
	end

	initial begin
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_ALLOC;
		req_ch.proc_id = '0;
		req_ch.req_size = '0;
		cfg_we = 1'b0;
		cfg_idx = cfwf_pkg::REG_TOTAL_CELLS;
		cfg_data = '0;
		pacing_on = 1'b1;
		foreach (cell_owner[k])
			cell_owner[k] = '0;
		cells_held = 0;
		ever_freed = 1'b0;
		cells_total = cfwf_pkg::RESET_TOTAL;
		fit_policy = cfwf_pkg::RESET_POLICY;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_first_fit();
		test_largest_hole();
		test_lowered_total();
		test_single_cell();
		test_zero_total();
		test_oversized_total();
		test_mid_total();
		test_switch_policy();

		wait_for_outcomes();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && awaited_outcomes.size() == 0)
			$display("[contiguous_first_worst_fit_allocator] OK");
		else
			$display("[contiguous_first_worst_fit_allocator] ERROR");
		$finish;
	end

endmodule
